// File: sv/vrap_pkg.sv
// Shared types, codes and address helpers for the video RAM access port.
// No dependencies; used by vrap_mem, vrap_ctrl and video_ram_access_port_top.
package vrap_pkg;

  localparam int MEMORY_BYTES_DEF = 65536;

  localparam int KIND_W = 3;
  localparam int ADDR_W = 15;

  localparam logic [KIND_W-1:0] KIND_MODE    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADDR_LO = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ADDR_HI = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DATA_LO = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DATA_HI = 3'd4;
  localparam logic [KIND_W-1:0] KIND_READ_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_READ_HI = 3'd6;

  localparam logic [1:0] STEP_1    = 2'd0;
  localparam logic [1:0] STEP_32   = 2'd1;

  localparam logic [1:0] REMAP_NONE = 2'd0;
  localparam logic [1:0] REMAP_8    = 2'd1;
  localparam logic [1:0] REMAP_9    = 2'd2;
  localparam logic [1:0] REMAP_10   = 2'd3;

  // Per-access memory request from the control unit.
  typedef struct packed {
    logic rd_en;
    logic wr_lo;
    logic wr_hi;
  } mem_req_t;

  // Rotate the low 8, 9 or 10 word address bits left by 3.
  function automatic logic [ADDR_W-1:0] remap(input logic [ADDR_W-1:0] a,
                                               input logic [1:0] mode);
    logic [ADDR_W-1:0] r;
    unique case (mode)
      REMAP_8:  r = {a[14:8], a[4:0], a[7:5]};
      REMAP_9:  r = {a[14:9], a[5:0], a[8:6]};
      REMAP_10: r = {a[14:10], a[6:0], a[9:7]};
      default:  r = a;
    endcase
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] step(input logic [ADDR_W-1:0] a,
                                              input logic [1:0] code);
    logic [ADDR_W-1:0] amount;
    unique case (code)
      STEP_1:  amount = ADDR_W'(1);
      STEP_32: amount = ADDR_W'(32);
      default: amount = ADDR_W'(128);
    endcase
    return a + amount;
  endfunction

endpackage

// File: sv/vrap_mem.sv
// Video memory: low and high byte banks, one word per entry, registered read.
// Runs a clearing pass after reset. Depends on vrap_pkg.
module vrap_mem #(
  parameter int MEMORY_BYTES = vrap_pkg::MEMORY_BYTES_DEF,
  localparam int WORDS = MEMORY_BYTES / 2,
  localparam int IDX_W = $clog2(WORDS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  vrap_pkg::mem_req_t   req,
  input  logic [IDX_W-1:0]     idx,
  input  logic [7:0]           wdata,
  output logic [15:0]          rdata,
  output logic                 busy
);

  logic [7:0] bank_lo [WORDS];
  logic [7:0] bank_hi [WORDS];

  logic             clearing;
  logic [IDX_W-1:0] clr_idx;

  assign busy = clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + IDX_W'(1);
      if (clr_idx == {IDX_W{1'b1}}) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      bank_lo[clr_idx] <= 8'h00;
      bank_hi[clr_idx] <= 8'h00;
    end else begin
      if (req.wr_lo) begin
        bank_lo[idx] <= wdata;
      end
      if (req.wr_hi) begin
        bank_hi[idx] <= wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rdata <= {bank_hi[idx], bank_lo[idx]};
    end
  end

endmodule

// File: sv/vrap_ctrl.sv
// Port control: word address, mode bits and prefetch latch, with the latch
// forwarded from memory read data while a refill is in flight. Depends on vrap_pkg.
module vrap_ctrl #(
  parameter int MEMORY_BYTES = vrap_pkg::MEMORY_BYTES_DEF,
  localparam int IDX_W = $clog2(MEMORY_BYTES / 2)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         fire,
  input  logic [vrap_pkg::KIND_W-1:0]  kind,
  input  logic [7:0]                   write_byte,
  input  logic                         forced_blank,
  input  logic [15:0]                  mem_rdata,
  output vrap_pkg::mem_req_t           mem_req,
  output logic [IDX_W-1:0]             mem_idx,
  output logic [7:0]                   mem_wdata,
  output logic [7:0]                   read_byte
);

  logic [vrap_pkg::ADDR_W-1:0] word_address, word_address_next;
  logic [vrap_pkg::ADDR_W-1:0] addr_sel, addr_remapped;
  logic [15:0] prefetch_latch, latch_view;
  logic [1:0]  step_code, remap_mode;
  logic        advance_on_high;
  logic        refill_pending;
  logic        advance, refill;

  // Latch contents as seen now: read data of a refill issued last cycle wins.
  assign latch_view = refill_pending ? mem_rdata : prefetch_latch;

  always_comb begin
    addr_sel = word_address;
    advance  = 1'b0;
    refill   = 1'b0;
    unique case (kind)
      vrap_pkg::KIND_ADDR_LO: begin
        addr_sel = {word_address[14:8], write_byte};
        refill   = 1'b1;
      end
      vrap_pkg::KIND_ADDR_HI: begin
        addr_sel = {write_byte[6:0], word_address[7:0]};
        refill   = 1'b1;
      end
      vrap_pkg::KIND_DATA_LO: advance = !advance_on_high;
      vrap_pkg::KIND_DATA_HI: advance = advance_on_high;
      vrap_pkg::KIND_READ_LO: begin
        advance = !advance_on_high;
        refill  = !advance_on_high;
      end
      vrap_pkg::KIND_READ_HI: begin
        advance = advance_on_high;
        refill  = advance_on_high;
      end
      default: ;
    endcase
  end

  assign addr_remapped = vrap_pkg::remap(addr_sel, remap_mode);
  assign mem_idx       = addr_remapped[IDX_W-1:0];
  assign mem_wdata     = write_byte;

  always_comb begin
    mem_req.rd_en = fire && refill;
    mem_req.wr_lo = fire && !forced_blank && (kind == vrap_pkg::KIND_DATA_LO);
    mem_req.wr_hi = fire && !forced_blank && (kind == vrap_pkg::KIND_DATA_HI);
  end

  always_comb begin
    if (kind == vrap_pkg::KIND_READ_LO) begin
      read_byte = latch_view[7:0];
    end else if (kind == vrap_pkg::KIND_READ_HI) begin
      read_byte = latch_view[15:8];
    end else begin
      read_byte = 8'h00;
    end
  end

  always_comb begin
    if (advance) begin
      word_address_next = vrap_pkg::step(word_address, step_code);
    end else begin
      word_address_next = addr_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_address    <= '0;
      prefetch_latch  <= '0;
      step_code       <= '0;
      remap_mode      <= '0;
      advance_on_high <= 1'b0;
      refill_pending  <= 1'b0;
    end else begin
      refill_pending <= fire && refill;
      if (refill_pending) begin
        prefetch_latch <= mem_rdata;
      end
      if (fire) begin
        word_address <= word_address_next;
        if (kind == vrap_pkg::KIND_MODE) begin
          step_code       <= write_byte[1:0];
          remap_mode      <= write_byte[3:2];
          advance_on_high <= write_byte[7];
        end
      end
    end
  end

  // A refill read is issued only for an accepted beat.
  assert property (@(posedge clk) disable iff (rst)
    mem_req.rd_en |-> fire)
    else $error("refill read without accepted beat");

  // Memory reads and writes never share a cycle.
  assert property (@(posedge clk) disable iff (rst)
    !(mem_req.rd_en && (mem_req.wr_lo || mem_req.wr_hi)))
    else $error("read and write issued together");

  // A pending refill lands in the latch on the next edge.
  assert property (@(posedge clk) disable iff (rst)
    refill_pending && !fire |=> prefetch_latch == $past(mem_rdata))
    else $error("prefetch latch missed refill data");

endmodule

// File: sv/video_ram_access_port_top.sv
// Top level of the video RAM access port: stream ports, forced blank register
// and output register. Depends on vrap_pkg, vrap_mem and vrap_ctrl.
//
// One bus access is taken per beat on the slave side and yields one beat on the
// master side on the next cycle, from an output register; a new access is taken in
// the same cycle the held result leaves, so the port sustains one access per clock
// while the master side keeps up. The prefetch latch is refilled from the
// registered video memory read and forwarded to a read that follows at once.
// After reset the memory clears one word per cycle, during which no beat is taken.
module video_ram_access_port_top #(
  parameter int MEMORY_BYTES = vrap_pkg::MEMORY_BYTES_DEF,
  localparam int IDX_W = $clog2(MEMORY_BYTES / 2)
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic        cfg_wdata,   // forced_blank
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,     // [7:0] write_byte
  input  logic [2:0]  s_tuser,     // [2:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata      // [7:0] read_byte
);

  logic               forced_blank;
  logic               fire;
  logic               mem_busy;
  vrap_pkg::mem_req_t mem_req;
  logic [IDX_W-1:0]   mem_idx;
  logic [7:0]         mem_wdata;
  logic [15:0]        mem_rdata;
  logic [7:0]         read_byte;

  assign s_tready = !mem_busy && (!m_tvalid || m_tready);
  assign fire     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      forced_blank <= 1'b0;
    end else if (cfg_wen) begin
      forced_blank <= cfg_wdata;
    end
  end

  vrap_ctrl #(.MEMORY_BYTES(MEMORY_BYTES)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .kind         (s_tuser),
    .write_byte   (s_tdata),
    .forced_blank (forced_blank),
    .mem_rdata    (mem_rdata),
    .mem_req      (mem_req),
    .mem_idx      (mem_idx),
    .mem_wdata    (mem_wdata),
    .read_byte    (read_byte)
  );

  vrap_mem #(.MEMORY_BYTES(MEMORY_BYTES)) u_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (mem_req),
    .idx   (mem_idx),
    .wdata (mem_wdata),
    .rdata (mem_rdata),
    .busy  (mem_busy)
  );

  // Hold the result until the master side takes the beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= read_byte;
    end
  end

  // Every accepted beat produces a result beat on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    fire |=> m_tvalid)
    else $error("accepted beat produced no result");

  // No beat is taken while the memory is being cleared.
  assert property (@(posedge clk) disable iff (rst)
    mem_busy |-> !s_tready)
    else $error("beat accepted during clearing pass");

  // Non-read accesses return a zero byte.
  assert property (@(posedge clk) disable iff (rst)
    fire && s_tuser != vrap_pkg::KIND_READ_LO && s_tuser != vrap_pkg::KIND_READ_HI
      |=> m_tdata == 8'h00)
    else $error("nonzero result for non-read access");

endmodule

// File: test/video_ram_access_port_top_tb.sv
// Self-checking bench for video_ram_access_port_top: a directed table, then random
// bus access bursts, checked against a behavioral model of the port.
// Depends on vrap_pkg and the port RTL.
`timescale 1ns / 100ps

module video_ram_access_port_top_tb;

  localparam logic [vrap_pkg::KIND_W-1:0] KIND_UNUSED = 3'd7;
  localparam int VRAM_BYTES = 65536;

  typedef struct {
    logic [2:0] kind;
    logic [7:0] wbyte;
    bit         known;   // result typed in below rather than predicted
    logic [7:0] want;
  } access_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_wen;
  logic       cfg_wdata;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic [2:0] s_tuser;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;

  video_ram_access_port_top u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Port model state
  logic [7:0]  vram [0:VRAM_BYTES-1];
  logic [14:0] cur_word;
  logic [15:0] latch;
  logic [1:0]  step_sel;
  logic [1:0]  remap_sel;
  logic        adv_hi;
  logic        blank;

  logic [7:0]  read_bytes_due [$];
  int          mismatches = 0;
  int          beats_out = 0;
  int          reads_sent = 0;
  int          writes_sent = 0;
  int          accesses_sent = 0;
  bit          steady = 1'b0;

  function automatic logic [14:0] mapped_word();
    logic [31:0] w;
    w = {17'd0, cur_word};
    case (remap_sel)
      vrap_pkg::REMAP_8:
        w = (w & 32'hFF00) | ((w & 32'h00E0) >> 5) | ((w & 32'h001F) << 3);
      vrap_pkg::REMAP_9:
        w = (w & 32'hFE00) | ((w & 32'h01C0) >> 6) | ((w & 32'h003F) << 3);
      vrap_pkg::REMAP_10:
        w = (w & 32'hFC00) | ((w & 32'h0380) >> 7) | ((w & 32'h007F) << 3);
      default:  w = w;
    endcase
    return w[14:0];
  endfunction

  function automatic void fetch_word();
    logic [14:0] w;
    w = mapped_word();
    latch = {vram[{w, 1'b1}], vram[{w, 1'b0}]};
  endfunction

  function automatic void advance_word();
    case (step_sel)
      vrap_pkg::STEP_1:  cur_word = cur_word + 15'd1;
      vrap_pkg::STEP_32: cur_word = cur_word + 15'd32;
      default:           cur_word = cur_word + 15'd128;
    endcase
  endfunction

  function automatic logic [7:0] predict_access(input logic [2:0] kind, input logic [7:0] b);
    logic [7:0]  rd;
    logic [14:0] w;
    rd = 8'h00;
    w = mapped_word();
    case (kind)
      vrap_pkg::KIND_MODE: begin
        step_sel  = b[1:0];
        remap_sel = b[3:2];
        adv_hi    = b[7];
      end
      vrap_pkg::KIND_ADDR_LO: begin
        cur_word[7:0] = b;
        fetch_word();
      end
      vrap_pkg::KIND_ADDR_HI: begin
        cur_word[14:8] = b[6:0];
        fetch_word();
      end
      vrap_pkg::KIND_DATA_LO: begin
        if (!blank) vram[{w, 1'b0}] = b;
        if (!adv_hi) advance_word();
      end
      vrap_pkg::KIND_DATA_HI: begin
        if (!blank) vram[{w, 1'b1}] = b;
        if (adv_hi) advance_word();
      end
      vrap_pkg::KIND_READ_LO: begin
        rd = latch[7:0];
        if (!adv_hi) begin
          fetch_word();
          advance_word();
        end
      end
      vrap_pkg::KIND_READ_HI: begin
        rd = latch[15:8];
        if (adv_hi) begin
          fetch_word();
          advance_word();
        end
      end
      default: ;
    endcase
    return rd;
  endfunction

  // Drive one access and wait until it is accepted; the predicted byte is queued on acceptance.
  task automatic send_access(input logic [2:0] kind, input logic [7:0] b,
                             input bit known = 1'b0, input logic [7:0] want = 8'h00);
    logic [7:0] rd;
    if (!steady && $urandom_range(99) < 9) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while (!steady && $urandom_range(99) < 9) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    rd = predict_access(kind, b);
    read_bytes_due.push_back(known ? want : rd);
    if (kind == vrap_pkg::KIND_READ_LO || kind == vrap_pkg::KIND_READ_HI) reads_sent++;
    else if (kind == vrap_pkg::KIND_DATA_LO || kind == vrap_pkg::KIND_DATA_HI)
      writes_sent++;
    if (kind != KIND_UNUSED) accesses_sent++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (read_bytes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_forced_blank(input logic v);
    drain_results();
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    blank = v;
  endtask

  // Mostly well-formed bursts: set mode, address, write a run, re-address, read back.
  task automatic random_bursts(input int count, input int calm_from, input int calm_to);
    int         start;
    int         n;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [2:0] k;
    start = accesses_sent;
    while (accesses_sent - start < count) begin
      steady = (accesses_sent - start >= calm_from) && (accesses_sent - start < calm_to);
      if ($urandom_range(99) < 80) begin
        send_access(vrap_pkg::KIND_MODE, 8'($urandom));
        lo = 8'($urandom);
        case ($urandom_range(3))
          0: hi = 8'h00;
          1: hi = 8'h7F;
          2: hi = 8'($urandom_range(3));
          default: hi = 8'($urandom);
        endcase
        send_access(vrap_pkg::KIND_ADDR_LO, lo);
        send_access(vrap_pkg::KIND_ADDR_HI, hi);
        n = $urandom_range(1, 8);
        repeat (n)
          send_access($urandom_range(1) ? vrap_pkg::KIND_DATA_HI : vrap_pkg::KIND_DATA_LO,
                      8'($urandom));
        if ($urandom_range(99) < 30) send_access(vrap_pkg::KIND_MODE, 8'($urandom));
        send_access(vrap_pkg::KIND_ADDR_LO, lo);
        send_access(vrap_pkg::KIND_ADDR_HI, hi);
        n = $urandom_range(1, 8);
        repeat (n)
          send_access($urandom_range(1) ? vrap_pkg::KIND_READ_HI : vrap_pkg::KIND_READ_LO,
                      8'($urandom));
      end else begin
        k = 3'($urandom_range(7));
        send_access(k, 8'($urandom));
      end
    end
    steady = 1'b0;
  endtask

  access_row_t directed_rows [26] = '{
    '{vrap_pkg::KIND_READ_LO, 8'h00, 1'b1, 8'h00},   // latch is clear after reset
    '{vrap_pkg::KIND_READ_HI, 8'hFF, 1'b1, 8'h00},
    '{KIND_UNUSED,            8'hFF, 1'b1, 8'h00},
    '{vrap_pkg::KIND_MODE,    8'h00, 1'b1, 8'h00},
    '{vrap_pkg::KIND_ADDR_LO, 8'hFF, 1'b1, 8'h00},
    '{vrap_pkg::KIND_ADDR_HI, 8'hFF, 1'b1, 8'h00},   // top bit dropped, top word
    '{vrap_pkg::KIND_DATA_LO, 8'hA5, 1'b1, 8'h00},   // address wraps to zero
    '{vrap_pkg::KIND_DATA_HI, 8'h5A, 1'b1, 8'h00},
    '{vrap_pkg::KIND_ADDR_LO, 8'hFF, 1'b1, 8'h00},
    '{vrap_pkg::KIND_ADDR_HI, 8'h7F, 1'b1, 8'h00},
    '{vrap_pkg::KIND_READ_LO, 8'h00, 1'b0, 8'h00},
    '{vrap_pkg::KIND_READ_HI, 8'h00, 1'b0, 8'h00},
    '{vrap_pkg::KIND_MODE,    8'h81, 1'b1, 8'h00},   // step 32, advance on high
    '{vrap_pkg::KIND_DATA_HI, 8'hFF, 1'b1, 8'h00},
    '{vrap_pkg::KIND_DATA_LO, 8'h00, 1'b1, 8'h00},
    '{vrap_pkg::KIND_MODE,    8'h0E, 1'b1, 8'h00},   // step 128, rotate 10 bits
    '{vrap_pkg::KIND_ADDR_LO, 8'h5C, 1'b1, 8'h00},
    '{vrap_pkg::KIND_DATA_LO, 8'h3C, 1'b1, 8'h00},
    '{vrap_pkg::KIND_READ_LO, 8'h00, 1'b0, 8'h00},
    '{vrap_pkg::KIND_MODE,    8'h79, 1'b1, 8'h00},   // step 32, rotate 9 bits, ignored bits set
    '{vrap_pkg::KIND_ADDR_HI, 8'h12, 1'b1, 8'h00},
    '{vrap_pkg::KIND_DATA_LO, 8'hC3, 1'b1, 8'h00},
    '{vrap_pkg::KIND_ADDR_HI, 8'h12, 1'b1, 8'h00},
    '{vrap_pkg::KIND_READ_HI, 8'h00, 1'b0, 8'h00},
    '{vrap_pkg::KIND_MODE,    8'hF7, 1'b1, 8'h00},   // step 128, rotate 8, advance on high
    '{vrap_pkg::KIND_READ_HI, 8'h00, 1'b0, 8'h00}
  };

  // Result side: check each beat, then decide whether to stall the next cycle.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        beats_out++;
        if (read_bytes_due.size() == 0) begin
          $error("read_byte: unexpected beat, actual %02h", m_tdata);
          mismatches++;
        end else begin
          if (m_tdata !== read_bytes_due[0]) begin
            $error("read_byte mismatch: expected %02h, actual %02h",
                   read_bytes_due[0], m_tdata);
            mismatches++;
          end
          void'(read_bytes_due.pop_front());
        end
      end
    end
    m_tready <= steady || ($urandom_range(99) >= 9);
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst       <= 1'b1;
    cfg_wen   <= 1'b0;
    cfg_wdata <= 1'b0;
    s_tvalid  <= 1'b0;
    s_tdata   <= 8'h00;
    s_tuser   <= vrap_pkg::KIND_MODE;
    m_tready  <= 1'b0;
    for (int i = 0; i < VRAM_BYTES; i++) vram[i] = 8'h00;
    cur_word  = '0;
    latch     = '0;
    step_sel  = '0;
    remap_sel = '0;
    adv_hi    = 1'b0;
    blank     = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    set_forced_blank(1'b0);
    foreach (directed_rows[i])
      send_access(directed_rows[i].kind, directed_rows[i].wbyte,
                  directed_rows[i].known, directed_rows[i].want);
    random_bursts(700, 250, 450);

    // Writes are dropped while blanked; the address still steps.
    set_forced_blank(1'b1);
    random_bursts(250, 0, 0);

    set_forced_blank(1'b0);
    random_bursts(500, 0, 0);

    drain_results();
    $display("tb: %0d accesses (%0d data writes, %0d reads), %0d result beats checked",
             accesses_sent, writes_sent, reads_sent, beats_out);
    $display("tb: forced blank toggled off, on, off; all step, remap and advance modes used");
    if (mismatches == 0 && read_bytes_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
